[hw/rtl/number_to_word_tokens_unit_defines.svh]
// ----------------------------------------------------------------------------
// Number to word tokens: assertion macros
// Assertion helpers shared by the RTL. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef NUMBER_TO_WORD_TOKENS_UNIT_DEFINES_SVH
`define NUMBER_TO_WORD_TOKENS_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define NTWT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define NTWT_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);
`else
`define NTWT_ASSERT(label, prop, msg)
`define NTWT_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

[hw/rtl/ntwt_pkg.sv]
// ----------------------------------------------------------------------------
// Number to word tokens: package
// Widths, token codes, sequencer states and digit position helpers.
// ----------------------------------------------------------------------------
package ntwt_pkg;

   localparam int VALUE_BITS = 40;
   localparam int WORD_BITS  = 5;
   localparam int BCD_DIGITS = 13;
   localparam int BCD_BITS   = 4 * BCD_DIGITS;
   localparam int CNT_BITS   = $clog2(VALUE_BITS);
   localparam int POS_BITS   = $clog2(BCD_DIGITS);

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [POS_BITS-1:0]  pos_type;
   typedef logic [3:0]           digit_type;

   localparam word_type TOK_ZERO         = word_type'(0);
   localparam word_type TOK_TEN          = word_type'(10);
   localparam word_type TOK_TENS_OFFSET  = word_type'(18);
   localparam word_type TOK_HUNDRED      = word_type'(28);
   localparam word_type TOK_THOUSAND     = word_type'(29);
   localparam word_type TOK_MILLION      = word_type'(30);
   localparam word_type TOK_BILLION      = word_type'(31);

   localparam pos_type POS_THOUSAND_OF_BILLION = pos_type'(12);
   localparam pos_type POS_BILLION             = pos_type'(9);
   localparam pos_type POS_MILLION             = pos_type'(6);
   localparam pos_type POS_THOUSAND            = pos_type'(3);
   localparam pos_type POS_TOP                 = pos_type'(BCD_DIGITS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_DIGIT,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      ROLE_UNITS    = 2'd0,
      ROLE_TENS     = 2'd1,
      ROLE_HUNDREDS = 2'd2
   } role_type;

   localparam role_type ROLE_TOP = role_type'(2'((BCD_DIGITS - 1) % 3));

   function automatic logic has_scale(pos_type pos);
      return pos inside {POS_THOUSAND_OF_BILLION, POS_BILLION, POS_MILLION, POS_THOUSAND};
   endfunction

   function automatic word_type scale_word(pos_type pos);
      word_type w;
      case (pos)
         POS_THOUSAND_OF_BILLION: w = TOK_THOUSAND;
         POS_BILLION:             w = TOK_BILLION;
         POS_MILLION:             w = TOK_MILLION;
         POS_THOUSAND:            w = TOK_THOUSAND;
         default:                 w = TOK_ZERO;
      endcase
      return w;
   endfunction

   // The thousands of billions share their nonzero flag with the billion group.
   function automatic logic keep_group(pos_type pos);
      return pos == POS_THOUSAND_OF_BILLION;
   endfunction

   function automatic role_type role_next(role_type role);
      role_type r;
      case (role)
         ROLE_UNITS:    r = ROLE_HUNDREDS;
         ROLE_TENS:     r = ROLE_UNITS;
         ROLE_HUNDREDS: r = ROLE_TENS;
         default:       r = ROLE_UNITS;
      endcase
      return r;
   endfunction

endpackage

[hw/rtl/number_to_word_tokens_unit.sv]
// Operation: binary to decimal shifting one bit at a time, then a walk over the decimal
// digits with an extra step for each Hundred or scale word emitted, then a closing state.
// A new number is accepted only in idle, after the last one has finished; rsp stalls
// hold the digit walk and the closing state.
// Reset clears all control state; the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
// Number to word tokens unit
// Converts a binary number to decimal digits bit by bit, then walks the digits
// from the most significant one and emits English number-word token codes.
// ----------------------------------------------------------------------------
`include "number_to_word_tokens_unit_defines.svh"

module number_to_word_tokens_unit import ntwt_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [WORD_BITS-1:0]  rsp_word,
   output logic                  rsp_last
);

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] bin_ff, bin_in;
   logic [BCD_BITS-1:0]   bcd_ff, bcd_in;
   logic [BCD_BITS-1:0]   bcd_adj;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   pos_type               pos_ff, pos_in;
   role_type              role_ff, role_in;
   logic                  ph_ff, ph_in;
   logic                  nz_ff, nz_in;
   logic                  teen_ff, teen_in;
   logic                  pend_valid_ff, pend_valid_in;
   word_type              pend_word_ff, pend_word_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   word_type              rsp_word_ff, rsp_word_in;
   logic                  rsp_last_ff, rsp_last_in;

   digit_type digit;
   digit_type next_digit;
   logic      nz_digit;
   logic      nz_upd;
   logic      out_free;
   logic      tok_en;
   word_type  tok;
   logic      need_second;
   logic      stall;

   assign digit      = bcd_ff[BCD_BITS-1 -: 4];
   assign next_digit = bcd_ff[BCD_BITS-5 -: 4];
   assign nz_digit   = (digit != 4'd0);
   assign nz_upd     = nz_ff | nz_digit;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      bin_in        = bin_ff;
      bcd_in        = bcd_ff;
      cnt_in        = cnt_ff;
      pos_in        = pos_ff;
      role_in       = role_ff;
      ph_in         = ph_ff;
      nz_in         = nz_ff;
      teen_in       = teen_ff;
      pend_valid_in = pend_valid_ff;
      pend_word_in  = pend_word_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_word_in   = rsp_word_ff;
      rsp_last_in   = rsp_last_ff;
      tok_en        = 1'b0;
      tok           = TOK_ZERO;
      need_second   = 1'b0;
      stall         = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               bin_in   = req_value;
               bcd_in   = '0;
               cnt_in   = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            bin_in = bin_ff << 1;
            bcd_in = {bcd_adj[BCD_BITS-2:0], bin_ff[VALUE_BITS-1]};
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(VALUE_BITS - 1)) begin
               state_in = ST_DIGIT;
               pos_in   = POS_TOP;
               role_in  = ROLE_TOP;
               ph_in    = 1'b0;
               nz_in    = 1'b0;
               teen_in  = 1'b0;
            end
         end
         ST_DIGIT: begin
            case (role_ff)
               ROLE_HUNDREDS: begin
                  if (!ph_ff) begin
                     tok_en      = nz_digit;
                     tok         = word_type'(digit);
                     need_second = nz_digit;
                  end else begin
                     tok_en = 1'b1;
                     tok    = TOK_HUNDRED;
                  end
               end
               ROLE_TENS: begin
                  if (digit >= 4'd2) begin
                     tok_en = 1'b1;
                     tok    = word_type'(digit) + TOK_TENS_OFFSET;
                  end else if (digit == 4'd1) begin
                     tok_en = 1'b1;
                     tok    = TOK_TEN + word_type'(next_digit);
                  end
               end
               ROLE_UNITS: begin
                  if (!ph_ff) begin
                     tok_en      = nz_digit && !teen_ff;
                     tok         = word_type'(digit);
                     need_second = has_scale(pos_ff) && nz_upd;
                  end else begin
                     tok_en = 1'b1;
                     tok    = scale_word(pos_ff);
                  end
               end
               default: begin
                  tok_en = 1'b0;
               end
            endcase

            stall = tok_en && pend_valid_ff && !out_free;

            if (!stall) begin
               if (tok_en) begin
                  pend_word_in  = tok;
                  pend_valid_in = 1'b1;
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_word_in  = pend_word_ff;
                     rsp_last_in  = 1'b0;
                  end
               end
               if (!ph_ff && need_second) begin
                  ph_in = 1'b1;
                  nz_in = nz_upd;
               end else begin
                  ph_in   = 1'b0;
                  bcd_in  = {bcd_ff[BCD_BITS-5:0], 4'd0};
                  pos_in  = pos_ff - pos_type'(1);
                  role_in = role_next(role_ff);
                  if (role_ff == ROLE_UNITS) begin
                     nz_in   = keep_group(pos_ff) ? nz_upd : 1'b0;
                     teen_in = 1'b0;
                  end else begin
                     nz_in   = nz_upd;
                     teen_in = (role_ff == ROLE_TENS) && (digit == 4'd1);
                  end
                  if (pos_ff == pos_type'(0)) begin
                     state_in = ST_FINISH;
                  end
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_word_in   = pend_valid_ff ? pend_word_ff : TOK_ZERO;
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         pos_ff        <= '0;
         role_ff       <= ROLE_UNITS;
         ph_ff         <= 1'b0;
         nz_ff         <= 1'b0;
         teen_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         pos_ff        <= pos_in;
         role_ff       <= role_in;
         ph_ff         <= ph_in;
         nz_ff         <= nz_in;
         teen_ff       <= teen_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff       <= bin_in;
      bcd_ff       <= bcd_in;
      pend_word_ff <= pend_word_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign rsp_last  = rsp_last_ff;

   `NTWT_ASSERT(a_idle_no_pending, (state_ff == ST_IDLE) |-> !pend_valid_ff, "pending token left in idle")
   `NTWT_ASSERT_NEXT(a_accept_starts_conv, req_valid && req_ready, state_ff == ST_CONV, "accepted beat did not start conversion")
   `NTWT_ASSERT(a_second_step_role, ph_ff |-> (role_ff != ROLE_TENS), "second step on a tens digit")
   `NTWT_ASSERT(a_teen_on_units, teen_ff |-> (role_ff == ROLE_UNITS), "teen flag outside a units digit")

endmodule
